// ===== src/rpip_pkg.sv =====
// Shared types, character codes and digit decoding for the integer parser.
package rpip_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned ProdWidth  = ValueWidth + 6;

  // Character codes.
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpX   = 8'h58;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowB  = 8'h62;
  localparam logic [7:0] CharLowO  = 8'h6F;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharLowZ  = 8'h7A;

  // Radix codes.
  localparam logic [5:0] RadixBin = 6'd2;
  localparam logic [5:0] RadixOct = 6'd8;
  localparam logic [5:0] RadixDec = 6'd10;
  localparam logic [5:0] RadixHex = 6'd16;
  localparam logic [5:0] RadixB36 = 6'd36;

  // Digit value of a byte that is no digit at all.
  localparam logic [6:0] NoDigit = 7'd99;

  typedef enum logic [7:0] {
    PhSign   = 8'b0000_0001,
    PhZero   = 8'b0000_0010,
    PhStart  = 8'b0000_0100,
    PhWs     = 8'b0000_1000,
    PhSigned = 8'b0001_0000,
    PhHex0   = 8'b0010_0000,
    PhHexX   = 8'b0100_0000,
    PhDig    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
    logic       empty_text;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic                  has_value;
    logic [ValueWidth-1:0] value;
  } res_t;

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [7:0] diff;
    begin
      diff = {1'b0, NoDigit};
      if (c >= CharZero && c <= CharNine) begin
        diff = c - CharZero;
      end else if (c >= CharLowA && c <= CharLowZ) begin
        diff = c - CharLowA + 8'd10;
      end else if (c >= CharUpA && c <= CharUpZ) begin
        diff = c - CharUpA + 8'd10;
      end
      digit_of = diff[6:0];
    end
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

endpackage

// ===== src/rpip_in_stage.sv =====
// Input register of the parser: holds one item and drives the input stall.
module rpip_in_stage import rpip_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       last_byte,
  input  logic       empty_text,
  input  logic       advance,
  output logic       item_valid,
  output item_t      item
);

  logic accept;

  assign text_stall = item_valid && !advance;
  assign accept     = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.text_byte  <= text_byte;
      item.last_byte  <= last_byte;
      item.empty_text <= empty_text;
    end
  end

endmodule

// ===== src/rpip_core.sv =====
// Parser state registers and the one-byte step with the final value check.
module rpip_core import rpip_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  item_t item,
  output res_t  result
);

  phase_t                phase, ph_n, p_ph;
  logic                  outer_neg, on_n;
  logic                  inner_neg, in_n;
  logic [5:0]            radix, rad_n, p_rad;
  logic [ValueWidth-1:0] mag, mag_n, p_mag;
  logic                  digit_seen, ds_n, p_ds;
  logic                  failed, f_n;
  logic                  text_ended, te_n;
  logic                  do_feed;
  logic                  go_digit;

  logic [7:0]            c;
  logic [6:0]            d;
  logic                  dlt;
  logic [ProdWidth-1:0]  prod;
  logic [ProdWidth-1:0]  sum;
  logic                  ovf;

  logic                  fin_ok;
  logic                  lim_bad;
  logic                  has;
  logic                  ends_text;
  logic [ValueWidth-1:0] value;

  assign c   = item.text_byte;
  assign d   = digit_of(c);
  assign dlt = {1'b0, p_rad} > d;

  // Prefix handling: resolves the sign and prefix phases into the state that
  // the strtoll part of the step starts from.
  always_comb begin
    p_ph    = phase;
    p_rad   = radix;
    p_mag   = mag;
    p_ds    = digit_seen;
    on_n    = outer_neg;
    do_feed = 1'b0;
    case (phase)
      PhSign: begin
        if (c == CharPlus || c == CharMinus) begin
          if (c == CharMinus) begin
            on_n = !outer_neg;
          end
        end else if (c == CharZero) begin
          p_ph = PhZero;
        end else if (c == CharHash) begin
          p_rad = RadixHex;
          p_ph  = PhStart;
        end else begin
          p_rad   = RadixDec;
          p_ph    = PhStart;
          do_feed = 1'b1;
        end
      end
      PhZero: begin
        if (c == CharLowX || c == CharUpX) begin
          p_rad = RadixHex;
          p_ph  = PhStart;
        end else if (c == CharLowO) begin
          p_rad = RadixOct;
          p_ph  = PhStart;
        end else if (c == CharLowB) begin
          p_rad = RadixBin;
          p_ph  = PhStart;
        end else if (c == CharLowZ) begin
          p_rad = RadixB36;
          p_ph  = PhStart;
        end else begin
          // The leading zero was a decimal digit after all.
          p_rad   = RadixDec;
          p_ph    = PhDig;
          p_ds    = 1'b1;
          p_mag   = '0;
          do_feed = 1'b1;
        end
      end
      default: begin
        do_feed = 1'b1;
      end
    endcase
  end

  // Multiply by the radix with shifts and adds, then add the digit.
  always_comb begin
    case (p_rad)
      RadixBin: prod = {5'd0, p_mag, 1'b0};
      RadixOct: prod = {3'd0, p_mag, 3'd0};
      RadixHex: prod = {2'd0, p_mag, 4'd0};
      RadixB36: prod = {1'b0, p_mag, 5'd0} + {4'd0, p_mag, 2'd0};
      default:  prod = {3'd0, p_mag, 3'd0} + {5'd0, p_mag, 1'b0};
    endcase
  end

  assign sum = prod + ProdWidth'(d);
  assign ovf = |sum[ProdWidth-1:ValueWidth];

  always_comb begin
    ph_n     = p_ph;
    rad_n    = p_rad;
    mag_n    = p_mag;
    ds_n     = p_ds;
    in_n     = inner_neg;
    f_n      = failed;
    te_n     = text_ended;
    go_digit = 1'b0;
    if (do_feed && !failed && !text_ended) begin
      case (p_ph)
        PhStart, PhWs: begin
          if (c == CharNul) begin
            if (p_ph == PhStart) begin
              te_n = 1'b1;
            end else begin
              f_n = 1'b1;
            end
          end else if (is_space(c)) begin
            ph_n = PhWs;
          end else if (c == CharPlus || c == CharMinus) begin
            in_n = (c == CharMinus);
            ph_n = PhSigned;
          end else if (p_rad == RadixHex && c == CharZero) begin
            ds_n = 1'b1;
            ph_n = PhHex0;
          end else begin
            go_digit = 1'b1;
          end
        end
        PhSigned: begin
          if (p_rad == RadixHex && c == CharZero) begin
            ds_n = 1'b1;
            ph_n = PhHex0;
          end else begin
            go_digit = 1'b1;
          end
        end
        PhHex0: begin
          if (c == CharLowX || c == CharUpX) begin
            ph_n = PhHexX;
          end else if (dlt) begin
            go_digit = 1'b1;
          end else if (c == CharNul) begin
            te_n = 1'b1;
          end else begin
            f_n = 1'b1;
          end
        end
        PhHexX: begin
          go_digit = 1'b1;
        end
        default: begin
          if (dlt) begin
            go_digit = 1'b1;
          end else if (c == CharNul) begin
            te_n = 1'b1;
          end else begin
            f_n = 1'b1;
          end
        end
      endcase
      if (go_digit) begin
        if (dlt) begin
          ds_n = 1'b1;
          ph_n = PhDig;
          if (ovf) begin
            f_n = 1'b1;
          end else begin
            mag_n = sum[ValueWidth-1:0];
          end
        end else begin
          f_n = 1'b1;
        end
      end
    end
  end

  // Final check on the last byte: accepting phase and signed range.
  assign fin_ok  = !f_n && (ph_n inside {PhZero, PhStart, PhHex0, PhDig});
  assign lim_bad = ds_n && mag_n[ValueWidth-1] && (!in_n || (|mag_n[ValueWidth-2:0]));
  assign has     = fin_ok && !lim_bad && !item.empty_text;
  assign value   = (in_n ^ on_n) ? ('0 - mag_n) : mag_n;

  assign ends_text        = item.last_byte || item.empty_text;
  assign result.valid     = step && ends_text;
  assign result.has_value = has;
  assign result.value     = has ? value : '0;

  always_ff @(posedge clk) begin
    if (rst || (step && ends_text)) begin
      phase      <= PhSign;
      outer_neg  <= 1'b0;
      inner_neg  <= 1'b0;
      radix      <= RadixDec;
      mag        <= '0;
      digit_seen <= 1'b0;
      failed     <= 1'b0;
      text_ended <= 1'b0;
    end else if (step) begin
      phase      <= ph_n;
      outer_neg  <= on_n;
      inner_neg  <= in_n;
      radix      <= rad_n;
      mag        <= mag_n;
      digit_seen <= ds_n;
      failed     <= f_n;
      text_ended <= te_n;
    end
  end

endmodule

// ===== src/rpip_out_stage.sv =====
// Result register of the parser with its output handshake.
module rpip_out_stage import rpip_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  res_t                         result,
  output logic                         free,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         has_value,
  output logic signed [ValueWidth-1:0] parsed_value
);

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result.valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      has_value    <= result.has_value;
      parsed_value <= $signed(result.value);
    end
  end

endmodule

// ===== src/radix_prefixed_integer_parser_unit.sv =====
// Throughput: one byte per cycle while no stalled result holds up the input;
// the parse state loop (shift-add by radix, digit add and overflow check) is
// a single registered step.
// Reset (rst, synchronous, active high) empties both registers and returns
// the parse state to the outer sign phase with radix ten.
module radix_prefixed_integer_parser_unit import rpip_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         text_valid,
  output logic                         text_stall,
  input  logic [7:0]                   text_byte,
  input  logic                         last_byte,
  input  logic                         empty_text,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         has_value,
  output logic signed [ValueWidth-1:0] parsed_value
);

  // The input register holds one item. It advances into the parse step
  // whenever the item yields no result, or the result register can take
  // the result it yields, so only a full, stalled result register can hold
  // up the input side.
  logic  item_valid;
  item_t item;
  logic  advance;
  logic  out_free;
  res_t  result;

  assign advance = item_valid &&
                   (!(item.last_byte || item.empty_text) || out_free);

  rpip_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_byte  (text_byte),
    .last_byte  (last_byte),
    .empty_text (empty_text),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // The core keeps the parse state and, on the last byte of a text, builds
  // the result and clears the state for the next text.
  rpip_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  rpip_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .result       (result),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .has_value    (has_value),
    .parsed_value (parsed_value)
  );

`ifndef SYNTHESIS
  // A text that gives no integer always reports zero.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !has_value |-> parsed_value == '0)
    else $error("none result carries a non-zero value");

  // The input side is only held up by a waiting, stalled result.
  assert property (@(posedge clk) disable iff (rst)
    text_stall |-> result_valid && result_stall)
    else $error("input stalled without a blocked result");

  // A byte that yields no result never waits in the input register.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item.last_byte && !item.empty_text |-> advance)
    else $error("non-final byte failed to advance");
`endif

endmodule

// ===== sim/tb_radix_prefixed_integer_parser_unit.sv =====
// Self-checking testbench for the radix-prefixed integer parser unit.
`timescale 1ns / 1ps

module tb_radix_prefixed_integer_parser_unit;
  import rpip_pkg::*;

  // With no item moving on either side for this many cycles, the run is stuck.
  localparam int unsigned StallLimit = 2000;

  typedef logic [7:0] text_q_t[$];

  typedef struct packed {
    logic                  has_val;
    logic [ValueWidth-1:0] number;
  } parse_result_t;

  logic                         clk;
  logic                         rst          = 1'b1;
  logic                         text_valid   = 1'b0;
  logic                         text_stall;
  logic [7:0]                   text_byte    = '0;
  logic                         last_byte    = 1'b0;
  logic                         empty_text   = 1'b0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic                         has_value;
  logic signed [ValueWidth-1:0] parsed_value;

  radix_prefixed_integer_parser_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .last_byte    (last_byte),
    .empty_text   (empty_text),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .has_value    (has_value),
    .parsed_value (parsed_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results still owed by the block, oldest first.
  parse_result_t expected_values[$];

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  // Shadow copy of the parser state, advanced once for every accepted item.
  phase_t      pr_phase;
  logic        pr_outer_neg;
  logic        pr_inner_neg;
  logic [5:0]  pr_radix;
  logic [63:0] pr_mag;
  logic        pr_digit_seen;
  logic        pr_failed;
  logic        pr_ended;

  function automatic void clear_parse();
    pr_phase      = PhSign;
    pr_outer_neg  = 1'b0;
    pr_inner_neg  = 1'b0;
    pr_radix      = RadixDec;
    pr_mag        = '0;
    pr_digit_seen = 1'b0;
    pr_failed     = 1'b0;
    pr_ended      = 1'b0;
  endfunction

  function automatic int unsigned char_digit(input logic [7:0] ch);
    if (ch >= CharZero && ch <= CharNine) return 32'(ch - CharZero);
    if (ch >= CharLowA && ch <= CharLowZ) return ch - CharLowA + 10;
    if (ch >= CharUpA && ch <= CharUpZ) return ch - CharUpA + 10;
    return 32'(NoDigit);
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == CharSpace || (ch >= CharTab && ch <= CharCr);
  endfunction

  // One more digit: the magnitude must still fit in 64 unsigned bits, or the
  // whole text is spoilt.
  function automatic void add_digit(input int unsigned d);
    logic [63:0] ceiling;
    pr_digit_seen = 1'b1;
    ceiling = ({64{1'b1}} - 64'(d)) / 64'(pr_radix);
    if (pr_mag > ceiling) begin
      pr_failed = 1'b1;
    end else begin
      pr_mag = pr_mag * 64'(pr_radix) + 64'(d);
    end
  endfunction

  // First character of the digit run. In radix sixteen a leading zero may
  // still be followed by an inner x.
  function automatic void start_digits(input logic [7:0] ch, input int unsigned d);
    if (pr_radix == RadixHex && ch == CharZero) begin
      pr_digit_seen = 1'b1;
      pr_phase      = PhHex0;
    end else if (d < pr_radix) begin
      add_digit(d);
      pr_phase = PhDig;
    end else begin
      pr_failed = 1'b1;
    end
  endfunction

  // Everything after the outer signs and the prefix is read the way the C
  // library reads an integer: blanks, one sign, an optional 0x in hex, digits.
  function automatic void feed_remainder(input logic [7:0] ch);
    int unsigned d;
    d = char_digit(ch);
    if (pr_ended || pr_failed) return;
    if (pr_phase == PhStart || pr_phase == PhWs) begin
      if (ch == CharNul) begin
        if (pr_phase == PhStart) pr_ended = 1'b1;
        else pr_failed = 1'b1;
      end else if (is_blank(ch)) begin
        pr_phase = PhWs;
      end else if (ch == CharPlus || ch == CharMinus) begin
        pr_inner_neg = (ch == CharMinus);
        pr_phase     = PhSigned;
      end else begin
        start_digits(ch, d);
      end
      return;
    end
    case (pr_phase)
      PhSigned: start_digits(ch, d);
      PhHex0: begin
        if (ch == CharLowX || ch == CharUpX) begin
          pr_phase = PhHexX;
        end else if (d < pr_radix) begin
          add_digit(d);
          pr_phase = PhDig;
        end else if (ch == CharNul) begin
          pr_ended = 1'b1;
        end else begin
          pr_failed = 1'b1;
        end
      end
      PhHexX: begin
        if (d < pr_radix) begin
          add_digit(d);
          pr_phase = PhDig;
        end else begin
          pr_failed = 1'b1;
        end
      end
      default: begin
        if (d < pr_radix) add_digit(d);
        else if (ch == CharNul) pr_ended = 1'b1;
        else pr_failed = 1'b1;
      end
    endcase
  endfunction

  // Advances the shadow state by one item; returns 1 when the item owes a
  // result, which is then left in res.
  function automatic bit parse_step(input logic [7:0] ch, input logic lst, input logic emp,
                                    output parse_result_t res);
    logic [5:0]  prefix_radix;
    logic        ok;
    logic [63:0] ceiling;
    logic [63:0] num;
    res = '0;
    if (emp) begin
      clear_parse();
      return 1'b1;
    end
    case (pr_phase)
      PhSign: begin
        if (ch == CharPlus || ch == CharMinus) begin
          if (ch == CharMinus) pr_outer_neg = !pr_outer_neg;
        end else if (ch == CharZero) begin
          pr_phase = PhZero;
        end else if (ch == CharHash) begin
          pr_radix = RadixHex;
          pr_phase = PhStart;
        end else begin
          pr_radix = RadixDec;
          pr_phase = PhStart;
          feed_remainder(ch);
        end
      end
      PhZero: begin
        prefix_radix = '0;
        if (ch == CharLowX || ch == CharUpX) prefix_radix = RadixHex;
        else if (ch == CharLowO) prefix_radix = RadixOct;
        else if (ch == CharLowB) prefix_radix = RadixBin;
        else if (ch == CharLowZ) prefix_radix = RadixB36;
        pr_phase = PhStart;
        if (prefix_radix != '0) begin
          pr_radix = prefix_radix;
        end else begin
          // The zero was an ordinary decimal digit after all.
          pr_radix = RadixDec;
          feed_remainder(CharZero);
          feed_remainder(ch);
        end
      end
      default: feed_remainder(ch);
    endcase
    if (!lst) return 1'b0;

    ok = 1'b0;
    if (!pr_failed) begin
      case (pr_phase)
        PhZero, PhStart, PhHex0, PhDig: ok = 1'b1;
        default: ok = 1'b0;
      endcase
    end
    // A negative inner sign allows one more step of magnitude.
    ceiling = 64'h7FFF_FFFF_FFFF_FFFF + {63'd0, pr_inner_neg};
    if (ok && pr_digit_seen && pr_mag > ceiling) ok = 1'b0;
    if (ok) begin
      num = pr_inner_neg ? 64'd0 - pr_mag : pr_mag;
      if (pr_outer_neg) num = 64'd0 - num;
      res.has_val = 1'b1;
      res.number  = num;
    end
    clear_parse();
    return 1'b1;
  endfunction

  // Offers one item, with a random gap ahead of it, and records what it owes
  // once the block has taken it. Valid is only lowered for a gap, so back to
  // back items keep it high.
  task automatic send_item(input logic [7:0] ch, input logic lst, input logic emp);
    parse_result_t res;
    if ($urandom_range(99) < send_gap_pct) begin
      text_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    text_valid <= 1'b1;
    text_byte  <= ch;
    last_byte  <= lst;
    empty_text <= emp;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    bytes_accepted++;
    if (parse_step(ch, lst, emp, res)) expected_values.push_back(res);
  endtask

  // Sends a byte sequence as one text; an empty one goes as an empty item.
  task automatic send_seq(input text_q_t q);
    if (q.size() == 0) begin
      send_item(8'($urandom), 1'($urandom), 1'b1);
      return;
    end
    for (int i = 0; i < q.size(); i++) send_item(q[i], i == q.size() - 1, 1'b0);
  endtask

  // One text from a string, optionally with a zero byte and a tail after it.
  task automatic send_text(input string head, input bit with_nul = 1'b0,
                           input string tail = "");
    text_q_t q;
    for (int i = 0; i < head.len(); i++) q.push_back(head[i]);
    if (with_nul) q.push_back(CharNul);
    for (int i = 0; i < tail.len(); i++) q.push_back(tail[i]);
    send_seq(q);
  endtask

  // Lets the block drain every owed result, then a few cycles for anything
  // stray that might still follow.
  task automatic wait_for_results();
    text_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed numbers with random content, plus some damaged ones.
  task automatic send_random_text();
    text_q_t     q;
    logic [5:0]  rdx;
    int unsigned max_len;
    int unsigned n_digits;
    int unsigned d;
    int unsigned pick;
    int unsigned pos;
    if ($urandom_range(99) < 5) begin
      send_item(8'($urandom), 1'($urandom), 1'b1);
      return;
    end
    repeat ($urandom_range(2)) q.push_back($urandom_range(1) ? CharMinus : CharPlus);
    rdx = RadixDec;
    case ($urandom_range(7))
      0: begin q.push_back(CharZero); q.push_back(CharLowX); rdx = RadixHex; end
      1: begin q.push_back(CharZero); q.push_back(CharUpX);  rdx = RadixHex; end
      2: begin q.push_back(CharZero); q.push_back(CharLowO); rdx = RadixOct; end
      3: begin q.push_back(CharZero); q.push_back(CharLowB); rdx = RadixBin; end
      4: begin q.push_back(CharZero); q.push_back(CharLowZ); rdx = RadixB36; end
      5: begin q.push_back(CharHash); rdx = RadixHex; end
      default: ;
    endcase
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        q.push_back($urandom_range(1) ? CharSpace : 8'($urandom_range(CharCr, CharTab)));
      end
    end
    if ($urandom_range(5) == 0) q.push_back($urandom_range(1) ? CharMinus : CharPlus);
    if (rdx == RadixHex && $urandom_range(5) == 0) begin
      q.push_back(CharZero);
      q.push_back($urandom_range(1) ? CharLowX : CharUpX);
    end

    // Digit counts cluster around the longest run that can still fit, so
    // that both sides of the overflow limit come up often.
    case (rdx)
      RadixBin: max_len = 64;
      RadixOct: max_len = 22;
      RadixHex: max_len = 16;
      RadixB36: max_len = 13;
      default:  max_len = 19;
    endcase
    pick = $urandom_range(9);
    if (pick == 0) n_digits = 0;
    else if (pick < 5) n_digits = $urandom_range(1, 4);
    else if (pick < 8) n_digits = $urandom_range(1, max_len);
    else n_digits = $urandom_range(max_len - 1, max_len + 1);
    repeat (n_digits) begin
      d = $urandom_range(rdx - 1);
      if (d < 10) q.push_back(CharZero + 8'(d));
      else q.push_back(($urandom_range(1) ? CharLowA : CharUpA) + 8'(d - 10));
    end

    // Damage: a stray byte, a zero byte, trailing junk, or a text cut short
    // by an empty item.
    pick = $urandom_range(99);
    pos  = (q.size() == 0) ? 0 : $urandom_range(q.size() - 1);
    if (pick < 8 && q.size() != 0) begin
      q[pos] = 8'($urandom);
    end else if (pick < 12) begin
      q.insert(pos, CharNul);
      if ($urandom_range(1)) q.push_back(8'($urandom));
    end else if (pick < 16) begin
      q.push_back(8'($urandom));
    end else if (pick < 19 && q.size() > 1) begin
      pos = $urandom_range(1, q.size() - 1);
      for (int i = 0; i < pos; i++) send_item(q[i], 1'b0, 1'b0);
      send_item(8'($urandom), 1'($urandom), 1'b1);
      return;
    end
    send_seq(q);
  endtask

  task automatic test_signs_and_prefixes();
    string texts[$];
    texts = '{"+", "-+-", "42", "--42", "0x1F", "0XfF", "0o17", "0b101", "0zZz",
              "#ff", "0", "0x", "-0b"};
    foreach (texts[i]) send_text(texts[i]);
  endtask

  task automatic test_blanks_and_inner_sign();
    string texts[$];
    texts = '{"  12", "#\t-1a", "0x 0x10", "#0x", "0o +7", " ", "#-"};
    foreach (texts[i]) send_text(texts[i]);
  endtask

  // A zero byte ends the text; anything after it is ignored.
  task automatic test_zero_byte_and_trailing();
    send_text("12", 1'b1, "z");
    send_text("", 1'b1);
    send_text("-", 1'b1);
    send_text(" ", 1'b1);
    send_text("#0", 1'b1, "5");
    send_text("12a");
    send_text("0o8");
  endtask

  task automatic test_overflow_limits();
    send_text("9223372036854775807");
    send_text("9223372036854775808");
    send_text("-9223372036854775808");
    send_text("# -8000000000000000");
    // Outer minus of the most negative value wraps back onto itself.
    send_text("-0x-8000000000000000");
    send_text("18446744073709551616");
  endtask

  task automatic test_empty_text();
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(CharLowA, 1'b0, 1'b1);
    // A text abandoned half way must leave no trace in the next one.
    send_item(CharMinus, 1'b0, 1'b0);
    send_item(CharHash, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_text("7");
  endtask

  task automatic test_random_texts(input int unsigned gap_pct, input int unsigned stall_pct,
                                   input int unsigned n_bytes);
    int unsigned first;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    first          = bytes_accepted;
    while (bytes_accepted - first < n_bytes) send_random_text();
    wait_for_results();
  endtask

  // The receiver holds off at random according to the current setting.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Every result taken is matched against the oldest one still owed.
  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: has_value %0b, parsed_value %0d",
                   has_value, parsed_value);
        end
      end else begin
        want = expected_values.pop_front();
        if (has_value !== want.has_val || parsed_value !== $signed(want.number)) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: has_value %0b, expected %0b; parsed_value %0d, expected %0d",
                     has_value, want.has_val, parsed_value, $signed(want.number));
          end
        end
      end
    end
  end

  // Watchdog: the run is given up once neither side has moved for too long.
  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("radix_prefixed_integer_parser_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_parse();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_signs_and_prefixes();
    test_blanks_and_inner_sign();
    test_zero_byte_and_trailing();
    test_overflow_limits();
    test_empty_text();
    wait_for_results();

    // Receiver stalls more often than the sender gaps, then the reverse, then flat out.
    test_random_texts(23, 58, 667);
    test_random_texts(58, 23, 667);
    test_random_texts(0, 0, 667);

    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("radix_prefixed_integer_parser_unit test passed");
    end else begin
      $display("radix_prefixed_integer_parser_unit test failed");
    end
    $finish;
  end

endmodule
